/* rtl/ifke_pkg.sv */
// shared types and constants of the ip flow key extractor
package ifke_pkg;

  // frame byte counter saturates here
  localparam int MAX_FRAME_BYTES = 16383;
  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  // width used for the length check, holds both the count and the needed length
  localparam int CMP_W = (POS_W > 9) ? POS_W : 9;
  // bytes past the l3 start that can hold a captured field
  localparam int CAP_SPAN = 44;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] FRAG_MASK = 16'h2000 | 16'h1FFF;
  localparam logic [19:0] LABEL_MASK = 20'hFFFFF;
  localparam logic [3:0] IPV4_IHL = 4'd5;
  localparam logic [8:0] IPV4_HDR_LEN = 9'd20;
  localparam logic [8:0] IPV6_HDR_LEN = 9'd40;
  localparam logic [8:0] PORT_BYTES = 9'd4;

  typedef enum logic [1:0] {
    FAM_NONE = 2'd0,
    FAM_IPV4 = 2'd1,
    FAM_IPV6 = 2'd2
  } family_e;

  // header fields captured while a frame streams in
  typedef struct packed {
    logic [31:0] first_word;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [31:0] ports;
  } capture_t;

  // everything known about a frame once its last byte is in
  typedef struct packed {
    logic [15:0]      ether_type;
    logic [7:0]       l3_offset;
    logic [POS_W-1:0] length;
    capture_t         cap;
  } frame_t;

  // one flow key with its verdict
  typedef struct packed {
    logic        verdict;
    family_e     family;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [8:0]  transport_offset;
    logic [19:0] v6_label;
  } result_t;

endpackage

/* rtl/ifke_capture.sv */
// byte counter and header field capture, frame register on the last byte
module ifke_capture (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 first_byte_i,
  input  logic                 last_byte_i,
  input  logic [15:0]          ether_type_i,
  input  logic [7:0]           header_offset_i,
  output logic                 frame_valid_o,
  input  logic                 frame_ready_i,
  output ifke_pkg::frame_t     frame_o
);

  logic [ifke_pkg::POS_W-1:0] pos_q, pos_d, pos, pos_n, diff;
  logic [15:0] ether_q, ether;
  logic [7:0] off_q, off;
  ifke_pkg::capture_t cap_q, cap_d, cap, cap_n;
  ifke_pkg::frame_t frame_q;
  logic frame_valid_q, frame_valid_d;
  logic accept, in_win;
  logic [5:0] rel;

  assign in_ready_o = !frame_valid_q || frame_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    ether = first_byte_i ? ether_type_i : ether_q;
    off = first_byte_i ? header_offset_i : off_q;
    pos = first_byte_i ? '0 : pos_q;
    cap = first_byte_i ? '0 : cap_q;
    diff = pos - ifke_pkg::POS_W'(off);
    in_win = (pos >= ifke_pkg::POS_W'(off)) && (diff < ifke_pkg::POS_W'(ifke_pkg::CAP_SPAN));
    rel = diff[5:0];
    cap_n = cap;
    pos_n = pos;
    if (pos < ifke_pkg::POS_W'(ifke_pkg::MAX_FRAME_BYTES)) begin
      pos_n = pos + ifke_pkg::POS_W'(1);
      if (in_win) begin
        if (ether == ifke_pkg::ETH_IPV4) begin
          if (rel < 6'd4) begin
            cap_n.first_word = {cap.first_word[23:0], data_byte_i};
          end else if (rel == 6'd6 || rel == 6'd7) begin
            cap_n.frag = {cap.frag[7:0], data_byte_i};
          end else if (rel == 6'd9) begin
            cap_n.proto = data_byte_i;
          end else if (rel >= 6'd12 && rel < 6'd16) begin
            cap_n.src_lo = {32'd0, cap.src_lo[23:0], data_byte_i};
          end else if (rel >= 6'd16 && rel < 6'd20) begin
            cap_n.dst_lo = {32'd0, cap.dst_lo[23:0], data_byte_i};
          end else if (rel >= 6'd20 && rel < 6'd24) begin
            cap_n.ports = {cap.ports[23:0], data_byte_i};
          end
        end else if (ether == ifke_pkg::ETH_IPV6) begin
          if (rel < 6'd4) begin
            cap_n.first_word = {cap.first_word[23:0], data_byte_i};
          end else if (rel == 6'd6) begin
            cap_n.proto = data_byte_i;
          end else if (rel >= 6'd8 && rel < 6'd16) begin
            cap_n.src_hi = {cap.src_hi[55:0], data_byte_i};
          end else if (rel >= 6'd16 && rel < 6'd24) begin
            cap_n.src_lo = {cap.src_lo[55:0], data_byte_i};
          end else if (rel >= 6'd24 && rel < 6'd32) begin
            cap_n.dst_hi = {cap.dst_hi[55:0], data_byte_i};
          end else if (rel >= 6'd32 && rel < 6'd40) begin
            cap_n.dst_lo = {cap.dst_lo[55:0], data_byte_i};
          end else if (rel >= 6'd40 && rel < 6'd44) begin
            cap_n.ports = {cap.ports[23:0], data_byte_i};
          end
        end
      end
    end
    // counter and captures restart after the last byte
    pos_d = last_byte_i ? '0 : pos_n;
    cap_d = last_byte_i ? '0 : cap_n;
    if (accept && last_byte_i) begin
      frame_valid_d = 1'b1;
    end else if (frame_ready_i) begin
      frame_valid_d = 1'b0;
    end else begin
      frame_valid_d = frame_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ether_q <= '0;
      off_q <= '0;
      cap_q <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      frame_valid_q <= frame_valid_d;
      if (accept) begin
        pos_q <= pos_d;
        ether_q <= ether;
        off_q <= off;
        cap_q <= cap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      frame_q <= '{ether_type: ether, l3_offset: off, length: pos_n, cap: cap_n};
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o = frame_q;

endmodule

/* rtl/ifke_verdict.sv */
// fast path checks and flow key build into the output register
module ifke_verdict (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 frame_valid_i,
  output logic                 frame_ready_o,
  input  ifke_pkg::frame_t     frame_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ifke_pkg::result_t    result_o
);

  ifke_pkg::result_t res_q, res_d;
  logic out_valid_q;
  logic advance, proto_ok, ok;
  logic [8:0] hdr_len, toff, need;
  ifke_pkg::family_e family;

  assign advance = !out_valid_q || out_ready_i;
  assign frame_ready_o = advance;

  always_comb begin
    proto_ok = (frame_i.cap.proto == ifke_pkg::PROTO_TCP) ||
               (frame_i.cap.proto == ifke_pkg::PROTO_UDP);
    if (frame_i.ether_type == ifke_pkg::ETH_IPV4) begin
      family = ifke_pkg::FAM_IPV4;
      hdr_len = ifke_pkg::IPV4_HDR_LEN;
      ok = (frame_i.cap.first_word[27:24] == ifke_pkg::IPV4_IHL) &&
           ((frame_i.cap.frag & ifke_pkg::FRAG_MASK) == 16'd0) && proto_ok;
    end else if (frame_i.ether_type == ifke_pkg::ETH_IPV6) begin
      family = ifke_pkg::FAM_IPV6;
      hdr_len = ifke_pkg::IPV6_HDR_LEN;
      ok = proto_ok;
    end else begin
      family = ifke_pkg::FAM_NONE;
      hdr_len = 9'd0;
      ok = 1'b0;
    end
    toff = {1'b0, frame_i.l3_offset} + hdr_len;
    need = toff + ifke_pkg::PORT_BYTES;
    // frame too short to hold the header and both ports
    if (ifke_pkg::CMP_W'(frame_i.length) < ifke_pkg::CMP_W'(need)) begin
      ok = 1'b0;
    end
    res_d = '0;
    if (!ok) begin
      res_d.verdict = 1'b1;
    end else begin
      res_d.family = family;
      res_d.proto = frame_i.cap.proto;
      res_d.src_hi = frame_i.cap.src_hi;
      res_d.src_lo = frame_i.cap.src_lo;
      res_d.dst_hi = frame_i.cap.dst_hi;
      res_d.dst_lo = frame_i.cap.dst_lo;
      res_d.src_port = frame_i.cap.ports[31:16];
      res_d.dst_port = frame_i.cap.ports[15:0];
      res_d.transport_offset = toff;
      res_d.v6_label = (family == ifke_pkg::FAM_IPV6) ?
                       (frame_i.cap.first_word[19:0] & ifke_pkg::LABEL_MASK) : 20'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && frame_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o = res_q;

endmodule

/* rtl/ip_flow_key_extractor.sv */
// top level of the ip flow key extractor
// Takes a frame one byte per cycle while s_axis_tready is high and, on the
// byte marked tlast, emits one flow key request per frame; only IPv4 or IPv6
// frames carrying TCP or UDP can get a key, the rest are marked drop. The byte
// marked in tuser starts a frame and samples the ethertype and the layer-3
// offset carried beside it in tdata. The key of a frame is registered first
// in the frame register and then in the output register, and
// m_axis_tuser set means drop (all key fields then read zero). A frame
// register and the output register sit between the two sides, so s_axis_tready
// drops only while both hold a key and the output side is stalled; every byte
// then waits, not only a last one. The byte counter stops at
// ifke_pkg::MAX_FRAME_BYTES and bytes beyond it are ignored. Bytes that arrive
// with no start marker continue as a new frame with the last sampled ethertype
// and offset.
module ip_flow_key_extractor (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [23:8] ether_type, [31:24] header_offset
  input  logic [31:0]  s_axis_tdata,
  // [0] first_byte
  input  logic         s_axis_tuser,
  // last_byte
  input  logic         s_axis_tlast,
  // flow key stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] addr_family, [9:2] ip_protocol, [73:10] src_addr_high,
  // [137:74] src_addr_low, [201:138] dst_addr_high, [265:202] dst_addr_low,
  // [281:266] src_port, [297:282] dst_port, [306:298] transport_offset,
  // [326:307] ipv6 label, [335:327] zero
  output logic [335:0] m_axis_tdata,
  // [0] verdict
  output logic         m_axis_tuser
);

  ifke_pkg::frame_t  frame;
  ifke_pkg::result_t result;
  logic frame_valid, frame_ready;

  // byte counting and field capture; frame snapshot on the last byte
  ifke_capture u_capture (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .data_byte_i     (s_axis_tdata[7:0]),
    .first_byte_i    (s_axis_tuser),
    .last_byte_i     (s_axis_tlast),
    .ether_type_i    (s_axis_tdata[23:8]),
    .header_offset_i (s_axis_tdata[31:24]),
    .frame_valid_o   (frame_valid),
    .frame_ready_i   (frame_ready),
    .frame_o         (frame)
  );

  // checks and key build into the output register
  ifke_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tuser = result.verdict;
  assign m_axis_tdata = {9'd0, result.v6_label, result.transport_offset,
                         result.dst_port, result.src_port, result.dst_lo,
                         result.dst_hi, result.src_lo, result.src_hi,
                         result.proto, result.family};

endmodule

/* verif/ip_flow_key_extractor_tb.sv */
// testbench for the ip flow key extractor: random framed byte stream, key prediction and checks
`timescale 1ns / 100ps

class flow_key_board;
  // frame state as the block should hold it
  logic [ifke_pkg::POS_W-1:0] pos;
  logic [15:0]                etype;
  logic [7:0]                 l3off;
  logic [31:0]                word0;
  logic [15:0]                frag;
  logic [7:0]                 proto;
  logic [63:0]                src_hi;
  logic [63:0]                src_lo;
  logic [63:0]                dst_hi;
  logic [63:0]                dst_lo;
  logic [31:0]                ports;

  ifke_pkg::result_t pending[$];
  int                made;
  int                seen;
  int                errors;

  function new();
    etype  = '0;
    l3off  = '0;
    made   = 0;
    seen   = 0;
    errors = 0;
    clear_fields();
  endfunction

  function void clear_fields();
    pos    = '0;
    word0  = '0;
    frag   = '0;
    proto  = '0;
    src_hi = '0;
    src_lo = '0;
    dst_hi = '0;
    dst_lo = '0;
    ports  = '0;
  endfunction

  // grab header bytes at fixed distances from the l3 start
  function void capture_byte(logic [7:0] b);
    int rel;
    rel = int'(pos) - int'(l3off);
    if (rel < 0) return;
    if (etype == ifke_pkg::ETH_IPV4) begin
      if (rel < 4) word0 = {word0[23:0], b};
      else if (rel == 6 || rel == 7) frag = {frag[7:0], b};
      else if (rel == 9) proto = b;
      else if (rel >= 12 && rel < 16) src_lo = {32'h0, src_lo[23:0], b};
      else if (rel >= 16 && rel < 20) dst_lo = {32'h0, dst_lo[23:0], b};
      else if (rel >= 20 && rel < 24) ports = {ports[23:0], b};
    end else if (etype == ifke_pkg::ETH_IPV6) begin
      if (rel < 4) word0 = {word0[23:0], b};
      else if (rel == 6) proto = b;
      else if (rel >= 8 && rel < 16) src_hi = {src_hi[55:0], b};
      else if (rel >= 16 && rel < 24) src_lo = {src_lo[55:0], b};
      else if (rel >= 24 && rel < 32) dst_hi = {dst_hi[55:0], b};
      else if (rel >= 32 && rel < 40) dst_lo = {dst_lo[55:0], b};
      else if (rel >= 40 && rel < 44) ports = {ports[23:0], b};
    end
  endfunction

  // one accepted input request; a last byte queues the key it must produce
  function void note_byte(logic [31:0] d, logic first, logic last);
    ifke_pkg::result_t k;
    ifke_pkg::family_e fam;
    logic              okay;
    int                hdr;
    if (first) begin
      etype = d[23:8];
      l3off = d[31:24];
      clear_fields();
    end
    if (int'(pos) < ifke_pkg::MAX_FRAME_BYTES) begin
      capture_byte(d[7:0]);
      pos = pos + 1'b1;
    end
    if (!last) return;
    k    = '0;
    hdr  = 0;
    fam  = ifke_pkg::FAM_NONE;
    okay = 1'b0;
    if (etype == ifke_pkg::ETH_IPV4) begin
      hdr  = 20;
      fam  = ifke_pkg::FAM_IPV4;
      // ihl is the low nibble of the first header byte
      okay = word0[27:24] == ifke_pkg::IPV4_IHL && (frag & ifke_pkg::FRAG_MASK) == '0 &&
             (proto == ifke_pkg::PROTO_TCP || proto == ifke_pkg::PROTO_UDP);
    end else if (etype == ifke_pkg::ETH_IPV6) begin
      hdr  = 40;
      fam  = ifke_pkg::FAM_IPV6;
      okay = proto == ifke_pkg::PROTO_TCP || proto == ifke_pkg::PROTO_UDP;
    end
    // frame must reach past the ports
    if (okay && int'(pos) < int'(l3off) + hdr + 4) okay = 1'b0;
    if (!okay) begin
      k.verdict = 1'b1;
    end else begin
      k.family           = fam;
      k.proto            = proto;
      k.src_hi           = src_hi;
      k.src_lo           = src_lo;
      k.dst_hi           = dst_hi;
      k.dst_lo           = dst_lo;
      k.src_port         = ports[31:16];
      k.dst_port         = ports[15:0];
      k.transport_offset = 9'(int'(l3off) + hdr);
      k.v6_label         = (fam == ifke_pkg::FAM_IPV6) ? word0[19:0] : 20'h0;
    end
    pending.push_back(k);
    made++;
    clear_fields();
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    // keep the log readable if the block is badly broken
    if (errors < 100)
      $display("mismatch on key %0d, %s: got %0h want %0h", seen, what, got, want);
    errors++;
  endtask

  task check_key(logic [335:0] d, logic drop);
    ifke_pkg::result_t w;
    if (pending.size() == 0) begin
      report("key with nothing pending", 0, 0);
      return;
    end
    w = pending.pop_front();
    seen++;
    if (drop !== w.verdict) report("verdict", drop, w.verdict);
    if (d[1:0] !== w.family) report("addr_family", d[1:0], w.family);
    if (d[9:2] !== w.proto) report("ip_protocol", d[9:2], w.proto);
    if (d[73:10] !== w.src_hi) report("src_addr_high", d[73:10], w.src_hi);
    if (d[137:74] !== w.src_lo) report("src_addr_low", d[137:74], w.src_lo);
    if (d[201:138] !== w.dst_hi) report("dst_addr_high", d[201:138], w.dst_hi);
    if (d[265:202] !== w.dst_lo) report("dst_addr_low", d[265:202], w.dst_lo);
    if (d[281:266] !== w.src_port) report("src_port", d[281:266], w.src_port);
    if (d[297:282] !== w.dst_port) report("dst_port", d[297:282], w.dst_port);
    if (d[306:298] !== w.transport_offset)
      report("transport_offset", d[306:298], w.transport_offset);
    if (d[326:307] !== w.v6_label) report("ipv6 label", d[326:307], w.v6_label);
    if (d[335:327] !== 9'h0) report("padding", d[335:327], 0);
  endtask
endclass

module ip_flow_key_extractor_tb;

  typedef enum int {FLAW_NONE, FLAW_IHL, FLAW_FRAG, FLAW_SHORT} flaw_e;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [335:0] m_axis_tdata;
  logic         m_axis_tuser;

  flow_key_board keys = new();
  logic [7:0]    frame_q[$];
  bit            src_calm;
  bit            hold_req;
  int            bytes_sent;

  ip_flow_key_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      keys.note_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      keys.check_key(m_axis_tdata, m_axis_tuser);
  end

  // key sink: random stall before each key, quiet stretches, one long hold on request
  initial begin
    int n;
    bit calm;
    m_axis_tready = 1'b1;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 7) == 0) calm = !calm;
      n = calm ? 0 : $urandom_range(0, 8);
      if (hold_req) begin
        hold_req = 1'b0;
        n = 200;
      end
      if (n != 0) begin
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
        m_axis_tready = 1'b1;
      end
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL ip_flow_key_extractor");
    $finish;
  end

  // offer one byte request and wait until it is taken
  task automatic push_byte(input logic [7:0] d, input bit first, input bit last,
                           input logic [15:0] et, input logic [7:0] ho);
    int n;
    n = src_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (n != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ho, et, d};
    s_axis_tuser  = first;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // sideband on bytes after the first is noise the block must ignore
  task automatic send_frame(input logic [15:0] et, input logic [7:0] ho,
                            input bit marked, input bit closed);
    for (int i = 0; i < frame_q.size(); i++)
      push_byte(frame_q[i], marked && i == 0, closed && i == frame_q.size() - 1,
                (i == 0) ? et : 16'($urandom), (i == 0) ? ho : 8'($urandom));
  endtask

  function automatic logic [7:0] pad_byte(fill_e fill);
    if (fill == FILL_ZERO) return 8'h00;
    if (fill == FILL_ONES) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic build_noise(input int len);
    frame_q.delete();
    repeat (len) frame_q.push_back(8'($urandom));
  endtask

  // link prefix, l3 header, port bytes and a tail, with an optional flaw
  task automatic build_frame(input bit v6, input int ho, input logic [7:0] prot,
                             input flaw_e flaw, input int tail, input fill_e fill);
    int         hdr;
    int         len;
    logic [3:0] ihl;
    logic [7:0] b0;
    logic [7:0] b6;
    logic [7:0] b7;
    hdr = v6 ? 40 : 20;
    frame_q.delete();
    repeat (ho + hdr + 4 + tail) frame_q.push_back(pad_byte(fill));
    if (v6) begin
      frame_q[ho + 6] = prot;
    end else begin
      ihl = ifke_pkg::IPV4_IHL;
      if (flaw == FLAW_IHL)
        do ihl = 4'($urandom); while (ihl == ifke_pkg::IPV4_IHL);
      b0 = frame_q[ho];
      b0[3:0] = ihl;
      frame_q[ho] = b0;
      b6 = frame_q[ho + 6];
      b7 = frame_q[ho + 7];
      if (flaw == FLAW_FRAG) begin
        if ({b6[5:0], b7} == 14'h0) b7 = 8'h01;
      end else begin
        // only the reserved and don't-fragment bits may stay set
        b6 = b6 & 8'hC0;
        b7 = 8'h00;
      end
      frame_q[ho + 6] = b6;
      frame_q[ho + 7] = b7;
      frame_q[ho + 9] = prot;
    end
    if (flaw == FLAW_SHORT) begin
      len = $urandom_range(1, ho + hdr + 3);
      while (frame_q.size() > len) void'(frame_q.pop_back());
    end
  endtask

  function automatic logic [7:0] pick_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'd14;
    if (r < 8) return 8'($urandom_range(0, 40));
    if (r == 8) return 8'($urandom);
    return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
  endfunction

  initial begin
    int         frames;
    int         kind;
    bit         v6;
    logic [7:0] ho;
    logic [7:0] prot;
    logic [15:0] et;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    src_calm      = 1'b0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // bytes with no start marker after reset: ethertype still zero, so drop
    for (int i = 0; i < 3; i++)
      push_byte(8'($urandom), 1'b0, i == 2, ifke_pkg::ETH_IPV4, 8'd14);
    // start and end on the same byte
    push_byte(8'hFF, 1'b1, 1'b1, ifke_pkg::ETH_IPV4, 8'd14);

    // field extremes on good frames
    build_frame(1'b0, 14, ifke_pkg::PROTO_TCP, FLAW_NONE, 0, FILL_ONES);
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    build_frame(1'b0, 0, ifke_pkg::PROTO_UDP, FLAW_NONE, 5, FILL_ZERO);
    send_frame(ifke_pkg::ETH_IPV4, 8'd0, 1'b1, 1'b1);
    build_frame(1'b1, 14, ifke_pkg::PROTO_TCP, FLAW_NONE, 2, FILL_ONES);
    send_frame(ifke_pkg::ETH_IPV6, 8'd14, 1'b1, 1'b1);
    build_frame(1'b1, 255, ifke_pkg::PROTO_UDP, FLAW_NONE, 0, FILL_ZERO);
    send_frame(ifke_pkg::ETH_IPV6, 8'd255, 1'b1, 1'b1);

    // each reason to drop an ip frame
    build_frame(1'b0, 14, ifke_pkg::PROTO_TCP, FLAW_IHL, 3, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    build_frame(1'b0, 14, ifke_pkg::PROTO_UDP, FLAW_NONE, 0, FILL_RANDOM);
    frame_q[20] = 8'h20; // more-fragments only
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    frame_q[20] = 8'h00; // fragment offset only
    frame_q[21] = 8'h01;
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    build_frame(1'b0, 14, 8'd1, FLAW_NONE, 0, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    build_frame(1'b1, 14, 8'd58, FLAW_NONE, 0, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV6, 8'd14, 1'b1, 1'b1);

    // one byte short of the ports, then exactly long enough
    build_frame(1'b0, 14, ifke_pkg::PROTO_TCP, FLAW_NONE, 0, FILL_RANDOM);
    void'(frame_q.pop_back());
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
    build_frame(1'b1, 14, ifke_pkg::PROTO_UDP, FLAW_NONE, 0, FILL_RANDOM);
    void'(frame_q.pop_back());
    send_frame(ifke_pkg::ETH_IPV6, 8'd14, 1'b1, 1'b1);
    build_frame(1'b1, 14, ifke_pkg::PROTO_UDP, FLAW_NONE, 0, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV6, 8'd14, 1'b1, 1'b1);

    // ethertypes next to the ip ones
    build_noise(50);
    send_frame(16'h0801, 8'd14, 1'b1, 1'b1);
    build_noise(60);
    send_frame(16'h86DC, 8'd14, 1'b1, 1'b1);
    build_noise(30);
    send_frame(16'hFFFF, 8'd0, 1'b1, 1'b1);

    // unmarked frame reuses the ipv6 ethertype and offset latched before it
    build_frame(1'b1, 14, ifke_pkg::PROTO_TCP, FLAW_NONE, 1, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV6, 8'd14, 1'b1, 1'b1);
    build_frame(1'b1, 14, ifke_pkg::PROTO_UDP, FLAW_NONE, 1, FILL_RANDOM);
    send_frame(16'h0000, 8'd0, 1'b0, 1'b1);

    // a new start marker in the middle of an open frame restarts it
    build_noise(10);
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b0);
    build_frame(1'b0, 14, ifke_pkg::PROTO_TCP, FLAW_NONE, 0, FILL_RANDOM);
    send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);

    // random part: mostly well formed frames, some flawed, some noise
    frames = 0;
    while (bytes_sent < 1950) begin
      src_calm = ($urandom_range(0, 4) == 0);
      frames++;
      if (frames == 1) begin
        // sink holds off while short frames keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (12) begin
          build_noise($urandom_range(1, 4));
          send_frame(ifke_pkg::ETH_IPV4, 8'd14, 1'b1, 1'b1);
        end
      end
      kind = $urandom_range(0, 99);
      v6   = $urandom_range(0, 1);
      ho   = pick_offset();
      et   = v6 ? ifke_pkg::ETH_IPV6 : ifke_pkg::ETH_IPV4;
      prot = ($urandom_range(0, 1) != 0) ? ifke_pkg::PROTO_TCP : ifke_pkg::PROTO_UDP;
      if (kind < 70) begin
        build_frame(v6, ho, prot, FLAW_NONE, $urandom_range(0, 6), FILL_RANDOM);
        send_frame(et, ho, 1'b1, 1'b1);
      end else if (kind < 85) begin
        if ($urandom_range(0, 3) == 0) prot = 8'($urandom);
        build_frame(v6, ho, prot, flaw_e'($urandom_range(0, 3)), $urandom_range(0, 4),
                    FILL_RANDOM);
        send_frame(et, ho, 1'b1, 1'b1);
      end else if (kind < 93) begin
        et = ($urandom_range(0, 1) != 0) ? 16'($urandom) : et ^ (16'h1 << $urandom_range(0, 15));
        build_noise($urandom_range(1, 40));
        send_frame(et, ho, 1'b1, 1'b1);
      end else if (kind < 97) begin
        build_frame(v6, ho, prot, FLAW_NONE, $urandom_range(0, 4), FILL_RANDOM);
        send_frame(et, ho, 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 20))
          push_byte(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0,
                    ($urandom_range(0, 1) != 0) ? et : 16'($urandom), ho);
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (keys.pending.size() != 0) @(posedge clk_i);
    // idle on after the last key so a stray extra key would still be caught
    repeat (20) @(posedge clk_i);
    if (keys.errors == 0)
      $display("PASS ip_flow_key_extractor");
    else
      $display("FAIL ip_flow_key_extractor");
    $finish;
  end

endmodule

/* files.f */
rtl/ifke_pkg.sv
rtl/ifke_capture.sv
rtl/ifke_verdict.sv
rtl/ip_flow_key_extractor.sv
verif/ip_flow_key_extractor_tb.sv
